// ===== hdl/mfhdr_pkg.sv =====
package mfhdr_pkg;

    // Sizing
    localparam int MAX_ORDER  = 8;
    localparam int MAX_PIXELS = 131072;
    localparam int AMP_BITS   = 16;
    localparam int PHASE_BITS = 16;

    localparam int SLOT_W  = $clog2(MAX_ORDER);
    localparam int POS_W   = $clog2(MAX_PIXELS);
    localparam int HELD_W  = $clog2(MAX_ORDER + 2);
    localparam int ORDER_W = 4;

    // Flag byte bit that marks a saturated pixel
    localparam int SAT_BIT = 3;

    localparam logic [SLOT_W:0]    ORDER_WRAP = (SLOT_W + 1)'(MAX_ORDER);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(MAX_ORDER - 1);
    localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(MAX_PIXELS - 1);
    localparam logic [HELD_W-1:0]  MIN_ORDER  = HELD_W'(2);
    localparam logic [HELD_W-1:0]  TOP_ORDER  = HELD_W'(MAX_ORDER);
    localparam logic [ORDER_W-1:0] ORDER_RST  = ORDER_W'(2);

    typedef struct packed {
        logic                  sat;
        logic [AMP_BITS-1:0]   amp;
        logic [PHASE_BITS-1:0] ph;
    } entry_t;

    // One memory word: all ring slots of one pixel position
    typedef entry_t [MAX_ORDER-1:0] hist_word_t;

    typedef struct packed {
        logic [15:0] amplitude;
        logic [15:0] phase;
        logic [7:0]  pixel_flags;
        logic        end_of_frame;
    } in_word_t;

    typedef struct packed {
        logic [15:0] merged_amplitude;
        logic [15:0] merged_phase;
        logic        from_history;
        logic        frame_done;
    } out_word_t;

    // Ring context of the word in the merge stage
    typedef struct packed {
        logic [SLOT_W-1:0] newest;
        logic [HELD_W-1:0] held;
    } ctx_t;

endpackage

// ===== hdl/mfhdr_hist_mem.sv =====
module mfhdr_hist_mem (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [mfhdr_pkg::POS_W-1:0]      rd_addr,
    output mfhdr_pkg::hist_word_t            rd_data,
    input  logic                             wr_en,
    input  logic [mfhdr_pkg::POS_W-1:0]      wr_addr,
    input  mfhdr_pkg::hist_word_t            wr_data
);
    import mfhdr_pkg::*;

    hist_word_t mem [MAX_PIXELS];
    hist_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // same-address write in this cycle: forward the new word
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mfhdr_select.sv =====
module mfhdr_select (
    input  mfhdr_pkg::in_word_t   item,
    input  mfhdr_pkg::ctx_t       ctx,
    input  mfhdr_pkg::hist_word_t rd_word,
    output mfhdr_pkg::hist_word_t wb_word,
    output mfhdr_pkg::out_word_t  result
);
    import mfhdr_pkg::*;

    always_comb
    begin
        entry_t                cur;
        hist_word_t            upd;
        logic [SLOT_W:0]       sum;
        logic [SLOT_W-1:0]     slot;
        logic [AMP_BITS-1:0]   best_amp;
        logic [PHASE_BITS-1:0] best_ph;
        logic                  found;

        cur.sat = item.pixel_flags[SAT_BIT];
        cur.amp = item.amplitude;
        cur.ph  = item.phase;

        upd = rd_word;
        upd[ctx.newest] = cur;

        best_amp = '0;
        best_ph  = '0;
        found    = 1'b0;

        // oldest age first; strict compare keeps the older entry on a tie
        for (int a = MAX_ORDER - 1; a >= 0; a--)
        begin
            sum = {1'b0, ctx.newest} + ORDER_WRAP - (SLOT_W + 1)'(a);
            if (sum >= ORDER_WRAP)
            begin
                sum = sum - ORDER_WRAP;
            end
            slot = sum[SLOT_W-1:0];
            if ((HELD_W'(a) < ctx.held) && !upd[slot].sat && (upd[slot].amp > best_amp))
            begin
                best_amp = upd[slot].amp;
                best_ph  = upd[slot].ph;
                found    = 1'b1;
            end
        end

        wb_word = upd;

        result.merged_amplitude = found ? best_amp : item.amplitude;
        result.merged_phase     = found ? best_ph  : item.phase;
        result.from_history     = found;
        result.frame_done       = item.end_of_frame;
    end

endmodule

// ===== hdl/multi_frame_hdr_max_amplitude_merge_unit.sv =====
// Channel   Dir  Handshake               Word
// in        in   in_valid / in_ready     in_data   (amplitude, phase, flags, end mark)
// out       out  out_valid / out_ready   out_data  (merged amp/phase, source, frame done)
// cfg       in   cfg_valid / cfg_ready   cfg_data  (history_order, 4 bits)
//
// Each pixel passes two stages: history memory read, then merge and write-back.
// They overlap, so one pixel per cycle is sustained while out_ready is high; the
// limit is the memory's single read port and single write port (same-address bypass).
// Reset clears ring pointer, frame count, pixel position and the pipeline;
// the history memory is not cleared (entries are undefined until written).
// out_ready low with out_valid high holds the merge stage; in_ready drops while held.
module multi_frame_hdr_max_amplitude_merge_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mfhdr_pkg::in_word_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mfhdr_pkg::out_word_t            out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mfhdr_pkg::ORDER_W-1:0]   cfg_data
);
    import mfhdr_pkg::*;

    // configuration
    logic [ORDER_W-1:0] order_reg;
    logic [HELD_W-1:0]  eff_order;

    // frame/ring control
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]  newest_reg, newest_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [HELD_W-1:0]  held_inc;
    logic               frame_start;

    // merge stage
    logic               busy_reg, busy_next;
    in_word_t           item_reg;
    ctx_t               ctx_reg;
    logic [POS_W-1:0]   addr_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_data_reg;

    logic               in_fire;
    logic               merge_fire;
    hist_word_t         rd_word;
    hist_word_t         wb_word;
    out_word_t          result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RST;
        end
        else if (cfg_valid)
        begin
            order_reg <= cfg_data;
        end
    end

    // clamp the order into 2..MAX_ORDER
    always_comb
    begin
        if (HELD_W'(order_reg) < MIN_ORDER)
        begin
            eff_order = MIN_ORDER;
        end
        else if (HELD_W'(order_reg) > TOP_ORDER)
        begin
            eff_order = TOP_ORDER;
        end
        else
        begin
            eff_order = HELD_W'(order_reg);
        end
    end

    // handshake: merge stage drains when the output register is free or taken
    assign merge_fire = busy_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !busy_reg || merge_fire;
    assign in_fire    = in_valid && in_ready;

    // ring advance at the first pixel of a frame
    always_comb
    begin
        frame_start = (pos_reg == '0);
        held_inc    = held_reg + HELD_W'(1);

        newest_next = newest_reg;
        held_next   = held_reg;
        pos_next    = pos_reg;

        if (in_fire)
        begin
            if (frame_start)
            begin
                newest_next = (newest_reg == LAST_SLOT) ? '0 : newest_reg + SLOT_W'(1);
                held_next   = (held_inc > eff_order) ? held_reg : held_inc;
            end
            if (in_data.end_of_frame || (pos_reg == LAST_POS))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
        end
        else if (merge_fire)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (merge_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            newest_reg    <= '0;
            held_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            newest_reg    <= newest_next;
            held_reg      <= held_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg       <= in_data;
            ctx_reg.newest <= newest_next;
            ctx_reg.held   <= held_next;
            addr_reg       <= pos_reg;
        end
        if (merge_fire)
        begin
            out_data_reg <= result;
        end
    end

    // read at accept, read-modify-write in the merge stage
    mfhdr_hist_mem u_mem (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (pos_reg),
        .rd_data (rd_word),
        .wr_en   (merge_fire),
        .wr_addr (addr_reg),
        .wr_data (wb_word)
    );

    mfhdr_select u_select (
        .item    (item_reg),
        .ctx     (ctx_reg),
        .rd_word (rd_word),
        .wb_word (wb_word),
        .result  (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while merge stage is stalled");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= TOP_ORDER)
        else $error("frame count beyond ring depth");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (busy_reg && (ctx_reg.held != '0)))
        else $error("accepted word not in merge stage with a live frame");

    a_merge_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        merge_fire |=> out_valid_reg)
        else $error("merged word lost");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        newest_reg <= LAST_SLOT)
        else $error("ring slot out of range");

endmodule
